// ----- hw/rtl/hwbs_pkg.sv -----
// shared types and constants for the health watch backoff supervisor
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package hwbs_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 32;

  // register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] REG_BASE_INTERVAL   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_BACKOFF_CEILING = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_RESPAWN_CAP     = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_STABLE_NEEDED   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_AUTO_RESTART    = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_LAUNCHER_READY  = 3'd5;

  localparam logic [15:0] BASE_INTERVAL_RST   = 16'd30;
  localparam logic [15:0] BACKOFF_CEILING_RST = 16'd300;
  localparam logic [7:0]  RESPAWN_CAP_RST     = 8'd5;
  localparam logic [7:0]  STABLE_NEEDED_RST   = 8'd3;
  localparam logic [7:0]  STABLE_RUN_MAX      = 8'd255;

  typedef struct packed {
    logic [15:0] base_interval;
    logic [15:0] backoff_ceiling;
    logic [7:0]  respawn_cap;
    logic [7:0]  stable_needed;
    logic        auto_restart;
    logic        launcher_ready;
  } cfg_t;

  typedef struct packed {
    logic        launch_ok;
    logic        child_alive;
    logic        probe_ok;
    logic [31:0] now_seconds;
  } item_t;

  typedef struct packed {
    logic [15:0] backoff_now;
    logic [7:0]  respawns;
    logic        gave_up;
    logic        kill_request;
    logic        launch_request;
    logic        healthy_now;
    logic        checked;
  } result_t;

endpackage

// ----- hw/rtl/health_watch_backoff_supervisor_top.sv -----
// Health watch supervisor with exponential respawn backoff. One beat on the in_ side is one
// tick; every tick yields exactly one out_ beat. The block takes a tick in every cycle while
// the result register is empty or being drained. A tick waits in the input register, then
// the decision logic, which reads and updates the supervisor state in the same cycle, writes
// the result register, and the state registers load with it, so back-to-back ticks see each
// other's effects. Configuration writes are always taken (cfg_ready is high) and must only
// be issued while no tick is in flight. The cfg_index values 0 to 5 select base_interval,
// backoff_ceiling, respawn_cap, stable_needed, auto_restart and launcher_ready; other
// indexes are ignored.
// depends on hwbs_pkg, hwbs_cfg and hwbs_core
`timescale 1ns / 1ps

module health_watch_backoff_supervisor_top import hwbs_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  input  logic                in_tvalid,
  output logic                in_tready,
  // now_seconds[31:0], probe_ok[32], child_alive[33], launch_ok[34], zero[39:35]
  input  logic [InDataW-1:0]  in_tdata,
  output logic                out_tvalid,
  input  logic                out_tready,
  // checked[0], healthy_now[1], launch_request[2], kill_request[3], gave_up[4],
  // respawns[12:5], backoff_now[28:13], zero[31:29]
  output logic [OutDataW-1:0] out_tdata
);

  cfg_t    cfg;
  item_t   item_r;
  logic    in_vld_r;
  logic    out_vld_r;
  result_t res_r;
  result_t res;
  logic    advance;
  logic    fire;

  assign cfg_ready = 1'b1;

  hwbs_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // the pipe moves when the result register is empty or being drained
  assign advance   = !out_vld_r || out_tready;
  assign in_tready = !in_vld_r || advance;
  assign fire      = in_vld_r && advance;

  hwbs_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .cfg   (cfg),
    .item  (item_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_vld_r <= in_tvalid;
      end
      if (advance) begin
        out_vld_r <= in_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= item_t'(in_tdata[34:0]);
    end
    if (fire) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {3'b000, res_r};

endmodule

// ----- hw/rtl/hwbs_cfg.sv -----
// configuration register file of the supervisor
// depends on hwbs_pkg for register indexes, reset values and cfg_t
`timescale 1ns / 1ps

module hwbs_cfg import hwbs_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  logic [CfgIdxW-1:0]  wr_index,
  input  logic [CfgDataW-1:0] wr_data,
  output cfg_t                cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        REG_BASE_INTERVAL:   cfg_nxt.base_interval   = wr_data;
        REG_BACKOFF_CEILING: cfg_nxt.backoff_ceiling = wr_data;
        REG_RESPAWN_CAP:     cfg_nxt.respawn_cap     = wr_data[7:0];
        REG_STABLE_NEEDED:   cfg_nxt.stable_needed   = wr_data[7:0];
        REG_AUTO_RESTART:    cfg_nxt.auto_restart    = wr_data[0];
        REG_LAUNCHER_READY:  cfg_nxt.launcher_ready  = wr_data[0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_interval   <= BASE_INTERVAL_RST;
      cfg_r.backoff_ceiling <= BACKOFF_CEILING_RST;
      cfg_r.respawn_cap     <= RESPAWN_CAP_RST;
      cfg_r.stable_needed   <= STABLE_NEEDED_RST;
      cfg_r.auto_restart    <= 1'b0;
      cfg_r.launcher_ready  <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- hw/rtl/hwbs_core.sv -----
// supervisor state and the per-tick decision logic
// depends on hwbs_pkg for cfg_t, item_t and result_t
`timescale 1ns / 1ps

module hwbs_core import hwbs_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    fire,
  input  cfg_t    cfg,
  input  item_t   item,
  output result_t res
);

  logic [31:0] last_check_r, last_check_nxt;
  logic        healthy_r, healthy_nxt;
  logic [7:0]  stable_run_r, stable_run_nxt;
  logic [7:0]  tally_r, tally_nxt;
  logic [15:0] backoff_r, backoff_nxt;
  logic        tracked_r, tracked_nxt;

  logic [15:0] interval;
  logic [31:0] elapsed;
  logic        due;
  logic [7:0]  stable_inc;
  logic [7:0]  tally_inc;
  logic [15:0] dbl_src;
  logic [16:0] dbl;
  logic [15:0] backoff_grown;

  assign interval   = (backoff_r != 16'd0) ? backoff_r : cfg.base_interval;
  assign elapsed    = item.now_seconds - last_check_r;
  assign due        = elapsed >= {16'd0, interval};
  assign stable_inc = (stable_run_r == STABLE_RUN_MAX) ? stable_run_r : stable_run_r + 8'd1;
  assign tally_inc  = tally_r + 8'd1;
  assign dbl_src    = (backoff_r == 16'd0) ? cfg.base_interval : backoff_r;
  assign dbl        = {dbl_src, 1'b0};
  // clamp the doubled value to the ceiling
  assign backoff_grown = (dbl > {1'b0, cfg.backoff_ceiling}) ? cfg.backoff_ceiling
                                                             : dbl[15:0];

  always_comb begin
    last_check_nxt = last_check_r;
    healthy_nxt    = healthy_r;
    stable_run_nxt = stable_run_r;
    tally_nxt      = tally_r;
    backoff_nxt    = backoff_r;
    tracked_nxt    = tracked_r;
    res            = '0;
    if (due) begin
      res.checked    = 1'b1;
      last_check_nxt = item.now_seconds;
      if (item.probe_ok) begin
        healthy_nxt    = 1'b1;
        stable_run_nxt = stable_inc;
        if (stable_inc >= cfg.stable_needed) begin
          tally_nxt   = 8'd0;
          backoff_nxt = 16'd0;
        end
      end else begin
        healthy_nxt    = 1'b0;
        stable_run_nxt = 8'd0;
        // a live tracked child is left alone
        if (cfg.auto_restart && !(tracked_r && item.child_alive)) begin
          if (tally_r >= cfg.respawn_cap) begin
            if (tracked_r) begin
              res.kill_request = 1'b1;
              tracked_nxt      = 1'b0;
            end
          end else begin
            tracked_nxt = 1'b0;
            if (cfg.launcher_ready) begin
              res.launch_request = 1'b1;
              tracked_nxt        = item.launch_ok;
            end
            tally_nxt   = tally_inc;
            backoff_nxt = backoff_grown;
            res.gave_up = tally_inc >= cfg.respawn_cap;
          end
        end
      end
    end
    res.healthy_now = healthy_nxt;
    res.respawns    = tally_nxt;
    res.backoff_now = backoff_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_check_r <= 32'd0;
      healthy_r    <= 1'b0;
      stable_run_r <= 8'd0;
      tally_r      <= 8'd0;
      backoff_r    <= 16'd0;
      tracked_r    <= 1'b0;
    end else if (fire) begin
      last_check_r <= last_check_nxt;
      healthy_r    <= healthy_nxt;
      stable_run_r <= stable_run_nxt;
      tally_r      <= tally_nxt;
      backoff_r    <= backoff_nxt;
      tracked_r    <= tracked_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_check_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !res.checked |=> $stable(last_check_r) && $stable(tally_r) && $stable(backoff_r))
    else $error("state moved on a tick that did not check");

  a_kill_excludes_launch: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.kill_request |-> !res.launch_request && !res.gave_up && !tracked_nxt)
    else $error("kill issued together with a respawn");

  a_failed_probe_clears_run: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.checked && !item.probe_ok |=> stable_run_r == 8'd0 && !healthy_r)
    else $error("failed probe did not clear the stable run");

  a_idle_holds_backoff: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(backoff_r) && $stable(tracked_r))
    else $error("state changed without a tick");
`endif

endmodule
